FILE: sv/br2_pkg.sv
package br2_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int IO_BITS       = 32;
    localparam int WIDTH_BITS    = 31;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [IO_BITS-1:0] ETA_RESET   = 32'h0002_0000;
    localparam logic [IO_BITS-1:0] SCALE_RESET = 32'h0001_0000;

    localparam logic CFG_ETA   = 1'b0;
    localparam logic CFG_SCALE = 1'b1;

    // tdata bit positions of the input transaction
    localparam int IN_DATA_BITS  = 160;
    localparam int IN_MEAN_LSB   = 0;
    localparam int IN_SLOPE_LSB  = 32;
    localparam int IN_WIDTH_LSB  = 64;
    localparam int IN_RM_LSB     = 95;
    localparam int IN_RS_LSB     = 127;
    localparam int OUT_DATA_BITS = 192;

    // one job handed from front to back: the window and the incoming cell
    typedef struct packed {
        logic [IO_BITS-1:0]    prev_mean;
        logic [IO_BITS-1:0]    prev_slope;
        logic [IO_BITS-1:0]    cen_mean;
        logic [IO_BITS-1:0]    cen_slope;
        logic [WIDTH_BITS-1:0] cen_width;
        logic [IO_BITS-1:0]    cen_rm;
        logic [IO_BITS-1:0]    cen_rs;
        logic [IO_BITS-1:0]    nxt_mean;
        logic [IO_BITS-1:0]    nxt_slope;
        logic                  last;
    } job_t;

endpackage

FILE: sv/br2_front.sv
module br2_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [br2_pkg::IN_DATA_BITS-1:0]     s_axis_tdata,
    input  logic [1:0]                           s_axis_tuser,
    output logic                                 job_valid,
    input  logic                                 job_ready,
    output br2_pkg::job_t                        job
);

    logic [1:0]                        fill_reg;
    logic [br2_pkg::IO_BITS-1:0]       pm_reg, ps_reg, cm_reg, cs_reg, crm_reg, crs_reg;
    logic [br2_pkg::WIDTH_BITS-1:0]    cw_reg;
    logic [1:0]                        fill_eff;
    logic                              accept;
    logic                              row_start, row_end;

    assign row_start = s_axis_tuser[0];
    assign row_end   = s_axis_tuser[1];
    assign fill_eff  = row_start ? 2'd0 : fill_reg;
    // a result job needs queue room; a shift-only cell does not
    assign s_axis_tready = (fill_eff != 2'd2) || job_ready;
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign job_valid = s_axis_tvalid && (fill_eff == 2'd2);

    always_comb
    begin
        job.prev_mean  = pm_reg;
        job.prev_slope = ps_reg;
        job.cen_mean   = cm_reg;
        job.cen_slope  = cs_reg;
        job.cen_width  = cw_reg;
        job.cen_rm     = crm_reg;
        job.cen_rs     = crs_reg;
        job.nxt_mean   = s_axis_tdata[br2_pkg::IN_MEAN_LSB +: br2_pkg::IO_BITS];
        job.nxt_slope  = s_axis_tdata[br2_pkg::IN_SLOPE_LSB +: br2_pkg::IO_BITS];
        job.last       = row_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= 2'd0;
            pm_reg <= '0; ps_reg <= '0; cm_reg <= '0; cs_reg <= '0;
            cw_reg <= '0; crm_reg <= '0; crs_reg <= '0;
        end
        else if (accept)
        begin
            pm_reg  <= cm_reg;
            ps_reg  <= cs_reg;
            cm_reg  <= s_axis_tdata[br2_pkg::IN_MEAN_LSB +: br2_pkg::IO_BITS];
            cs_reg  <= s_axis_tdata[br2_pkg::IN_SLOPE_LSB +: br2_pkg::IO_BITS];
            cw_reg  <= s_axis_tdata[br2_pkg::IN_WIDTH_LSB +: br2_pkg::WIDTH_BITS];
            crm_reg <= s_axis_tdata[br2_pkg::IN_RM_LSB +: br2_pkg::IO_BITS];
            crs_reg <= s_axis_tdata[br2_pkg::IN_RS_LSB +: br2_pkg::IO_BITS];
            if (row_end)
                fill_reg <= 2'd0;
            else if (fill_eff != 2'd2)
                fill_reg <= fill_eff + 2'd1;
            else
                fill_reg <= 2'd2;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) fill_reg != 2'd3)
        else $error("window fill out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_axis_tuser[1] |=> fill_reg == 2'd0)
        else $error("row end did not clear window");
    assert property (@(posedge clk) disable iff (!rst_n)
        job_valid |-> s_axis_tvalid)
        else $error("job without input");

endmodule

FILE: sv/br2_queue.sv
module br2_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  br2_pkg::job_t wr_job,
    output logic          rd_valid,
    input  logic          rd_ready,
    output br2_pkg::job_t rd_job
);

    localparam int PW = $clog2(br2_pkg::QUEUE_DEPTH);

    br2_pkg::job_t mem_reg [br2_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [PW:0]   cnt_reg;
    logic          push, pop;

    assign wr_ready = cnt_reg != (PW+1)'(br2_pkg::QUEUE_DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign push = wr_valid && wr_ready;
    assign pop  = rd_valid && rd_ready;
    assign rd_job = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= wp_reg + PW'(1);
            if (pop)  rp_reg <= rp_reg + PW'(1);
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (PW+1)'(br2_pkg::QUEUE_DEPTH))
        else $error("queue overflow");

endmodule

FILE: sv/br2_back.sv
module br2_back #(
    parameter int WORD_BITS = br2_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = br2_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               job_valid,
    output logic                               job_ready,
    input  br2_pkg::job_t                      job,
    input  logic [br2_pkg::IO_BITS-1:0]        eta,
    input  logic [br2_pkg::IO_BITS-1:0]        scale,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [br2_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
    output logic                               m_axis_tlast
);

    localparam int W  = WORD_BITS;
    localparam int PB = 2 * W;           // product magnitude width
    localparam int NB = W + FRAC_BITS;   // dividend width
    localparam int CB = $clog2(NB + 1);
    localparam int IO = br2_pkg::IO_BITS;
    localparam int HW = br2_pkg::WIDTH_BITS;
    localparam int HB = HW + 1;          // 2h width
    localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE, S_JUMP, S_MUL, S_DIV, S_LIFT, S_FLUX, S_SCL, S_SUM, S_OUT
    } state_t;

    typedef enum logic [1:0] { D_QL, D_QR, D_G } dsel_t;

    state_t state_reg;
    dsel_t  dsel_reg;
    logic [1:0] msel_reg;

    logic signed [W-1:0] cm_reg, cs_reg, crm_reg, crs_reg, jl_reg, jr_reg;
    logic signed [W-1:0] ql_reg, qr_reg, g_reg, fl_reg, fr_reg, tm_reg;
    logic signed [W-1:0] pa_reg, pb_reg, pc_reg, rm_reg, rs_reg;
    logic signed [W-1:0] l0_reg, l1_reg, r0_reg, r1_reg;
    logic signed [W-1:0] eta_w, c_w;
    logic [HB-1:0]       h_reg;    // 2h, independent of the word width
    logic [HW-1:0]       hw;
    logic                last_reg;

    // shared divider: restoring, one bit a cycle
    logic [NB-1:0] dn_reg, dq_reg;
    logic [HB:0]   dr_reg;
    logic [CB-1:0] dcnt_reg;
    logic          dneg_reg;
    logic [HB:0]   rtry;
    logic [HB:0]   dsub;

    // shared multiplier
    logic signed [W-1:0] ma, mb, mres;

    function automatic logic signed [W-1:0] clampw(input logic signed [W+1:0] v);
        if (v > $signed({{2{1'b0}}, WMAX})) return WMAX;
        if (v < $signed({{2{1'b1}}, WMIN})) return WMIN;
        return v[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
        return clampw((W+2)'(a) + (W+2)'(b));
    endfunction

    function automatic logic signed [W-1:0] ssub(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
        return clampw((W+2)'(a) - (W+2)'(b));
    endfunction

    function automatic logic signed [W-1:0] ext(input logic [IO-1:0] x);
        logic signed [IO+W-1:0] v;
        v = (IO+W)'($signed(x));
        if (v > (IO+W)'(WMAX)) return WMAX;
        if (v < (IO+W)'(WMIN)) return WMIN;
        return v[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] mulq(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
        logic [W-1:0]  aa, bb;
        logic [PB-1:0] p, r;
        logic          neg;
        aa = a[W-1] ? W'(-a) : W'(a);
        bb = b[W-1] ? W'(-b) : W'(b);
        p = PB'(aa) * PB'(bb);
        r = p >> FRAC_BITS;
        neg = a[W-1] ^ b[W-1];
        if (neg)
            return (r > PB'(WMAX) + PB'(1)) ? WMIN : W'(PB'(0) - r);
        return (r > PB'(WMAX)) ? WMAX : W'(r);
    endfunction

    assign eta_w = ext(eta);
    assign c_w   = ext(scale);
    assign mres  = mulq(ma, mb);
    assign dsub  = {dr_reg[HB-1:0], dn_reg[NB-1]}
                   - (HB+1)'(dsel_reg == D_G ? h_reg >> 1 : h_reg);
    assign rtry  = {dr_reg[HB-1:0], dn_reg[NB-1]};
    assign hw    = job.cen_width == '0 ? HW'(1) : job.cen_width;

    always_comb
    begin
        unique case (msel_reg)
            2'd0: begin ma = eta_w; mb = jl_reg; end
            2'd1: begin ma = eta_w; mb = jr_reg; end
            2'd2: begin ma = c_w;   mb = fr_reg; end
            default: begin ma = c_w; mb = fl_reg; end
        endcase
    end

    assign job_ready    = state_reg == S_IDLE;
    assign m_axis_tdata = {IO'(r1_reg), IO'(r0_reg), IO'(l1_reg), IO'(l0_reg),
                           IO'(rs_reg), IO'(rm_reg)};
    assign m_axis_tlast = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            m_axis_tvalid <= 1'b0;
            msel_reg <= 2'd0;
            dsel_reg <= D_QL;
            dcnt_reg <= '0;
            cm_reg <= '0; cs_reg <= '0; crm_reg <= '0; crs_reg <= '0;
            jl_reg <= '0; jr_reg <= '0; ql_reg <= '0; qr_reg <= '0;
            g_reg <= '0; fl_reg <= '0; fr_reg <= '0; tm_reg <= '0;
            pa_reg <= '0; pb_reg <= '0; pc_reg <= '0; rm_reg <= '0; rs_reg <= '0;
            l0_reg <= '0; l1_reg <= '0; r0_reg <= '0; r1_reg <= '0;
            h_reg <= '0; last_reg <= 1'b0;
            dn_reg <= '0; dq_reg <= '0; dr_reg <= '0; dneg_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        cm_reg <= ext(job.cen_mean);
                        cs_reg <= ext(job.cen_slope);
                        crm_reg <= ext(job.cen_rm);
                        crs_reg <= ext(job.cen_rs);
                        h_reg <= {hw, 1'b0};
                        last_reg <= job.last;
                        jl_reg <= ssub(sadd(ext(job.prev_mean), ext(job.prev_slope)),
                                       ssub(ext(job.cen_mean), ext(job.cen_slope)));
                        pa_reg <= ssub(ext(job.nxt_mean), ext(job.nxt_slope));
                        state_reg <= S_JUMP;
                    end
                end
                S_JUMP:
                begin
                    jr_reg <= ssub(pa_reg, sadd(cm_reg, cs_reg));
                    msel_reg <= 2'd0;
                    dsel_reg <= D_QL;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    // load the divider with the dividend for this pass
                    if (dsel_reg == D_G)
                    begin
                        dneg_reg <= cs_reg[W-1];
                        dn_reg <= NB'(cs_reg[W-1] ? W'(-cs_reg) : W'(cs_reg)) << FRAC_BITS;
                    end
                    else
                    begin
                        dneg_reg <= mres[W-1];
                        dn_reg <= NB'(mres[W-1] ? W'(-mres) : W'(mres)) << FRAC_BITS;
                    end
                    dr_reg <= '0;
                    dq_reg <= '0;
                    dcnt_reg <= CB'(NB);
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (dcnt_reg != '0)
                    begin
                        dn_reg <= dn_reg << 1;
                        if (!dsub[HB])
                        begin
                            dr_reg <= dsub;
                            dq_reg <= {dq_reg[NB-2:0], 1'b1};
                        end
                        else
                        begin
                            dr_reg <= rtry;
                            dq_reg <= {dq_reg[NB-2:0], 1'b0};
                        end
                        dcnt_reg <= dcnt_reg - CB'(1);
                    end
                    else
                    begin
                        pb_reg <= dneg_reg
                            ? ((dq_reg > NB'(WMAX) + NB'(1)) ? WMIN : W'(NB'(0) - dq_reg))
                            : ((dq_reg > NB'(WMAX)) ? WMAX : W'(dq_reg));
                        state_reg <= S_LIFT;
                    end
                end
                S_LIFT:
                begin
                    unique case (dsel_reg)
                        D_QL:
                        begin
                            ql_reg <= pb_reg;
                            msel_reg <= 2'd1;
                            dsel_reg <= D_QR;
                            state_reg <= S_MUL;
                        end
                        D_QR:
                        begin
                            qr_reg <= pb_reg;
                            dsel_reg <= D_G;
                            state_reg <= S_MUL;
                        end
                        default:
                        begin
                            g_reg <= pb_reg;
                            l0_reg <= ssub('0, ql_reg);
                            l1_reg <= sadd(ql_reg, sadd(ql_reg, ql_reg));
                            r0_reg <= ssub('0, qr_reg);
                            r1_reg <= ssub('0, sadd(qr_reg, sadd(qr_reg, qr_reg)));
                            state_reg <= S_FLUX;
                        end
                    endcase
                end
                S_FLUX:
                begin
                    fl_reg <= ssub(g_reg, ssub(l0_reg, l1_reg));
                    fr_reg <= ssub(g_reg, sadd(r0_reg, r1_reg));
                    tm_reg <= ssub(ssub(g_reg, l0_reg), r0_reg);
                    state_reg <= S_SCL;
                end
                S_SCL:
                begin
                    // reuse fr/fl as multiplier operands: diff, sum, then t
                    fr_reg <= ssub(fr_reg, fl_reg);
                    fl_reg <= sadd(fr_reg, fl_reg);
                    msel_reg <= 2'd2;
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    if (msel_reg == 2'd2)
                    begin
                        pa_reg <= mres;
                        msel_reg <= 2'd3;
                    end
                    else if (msel_reg == 2'd3)
                    begin
                        pb_reg <= mres;
                        fl_reg <= tm_reg;
                        msel_reg <= 2'd0;
                        pc_reg <= '0;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!m_axis_tvalid)
                    begin
                        rm_reg <= sadd(crm_reg, pa_reg);
                        pc_reg <= mulq(c_w, fl_reg);
                        if (msel_reg == 2'd0)
                        begin
                            rs_reg <= sadd(crs_reg, pb_reg);
                            msel_reg <= 2'd1;
                        end
                        else
                        begin
                            rs_reg <= ssub(rs_reg, sadd(pc_reg, pc_reg));
                            m_axis_tvalid <= 1'b1;
                        end
                    end
                    else if (m_axis_tready)
                    begin
                        m_axis_tvalid <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> state_reg == S_OUT)
        else $error("result shown outside output state");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> dcnt_reg <= CB'(NB))
        else $error("divider count out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        job_ready |-> !m_axis_tvalid)
        else $error("idle with pending result");

endmodule

FILE: sv/br2_diffusion_rhs_p1.sv
// Channel   Dir  tdata (low to high)                                   tuser / tlast
// s_axis    in   cell_mean, cell_slope, cell_width, rhs_mean_in,       tuser: row_start,
//                rhs_slope_in                                           row_end
// m_axis    out  rhs_mean_out, rhs_slope_out, lift_left_mean/slope,    tlast: last_result
//                lift_right_mean/slope
// cfg       in   cfg_we, cfg_index (0 eta, 1 scale), cfg_data
// A cell that only fills the window is accepted without waiting for queue room. A cell that
// produces a result holds the back end while the bit-serial divider runs three times
// (two liftings and the slope gradient).
// A two-entry queue sits between the window front and the compute back.
// Reset clears the window, queue and registers to their reset values.
// A stalled m_axis holds the back end; the front keeps taking cells while the queue has room.
module br2_diffusion_rhs_p1 #(
    parameter int WORD_BITS = br2_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = br2_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // cell_mean, cell_slope, cell_width, rhs_mean_in, rhs_slope_in, zero pad
    input  logic [br2_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
    // row_start, row_end
    input  logic [1:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // rhs_mean_out, rhs_slope_out, lift_left_mean, lift_left_slope,
    // lift_right_mean, lift_right_slope
    output logic [br2_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
    output logic                               m_axis_tlast,
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [br2_pkg::IO_BITS-1:0]        cfg_data
);

    logic [br2_pkg::IO_BITS-1:0] eta_reg, scale_reg;
    logic          fj_valid, fj_ready, bj_valid, bj_ready;
    br2_pkg::job_t fj, bj;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eta_reg   <= br2_pkg::ETA_RESET;
            scale_reg <= br2_pkg::SCALE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                br2_pkg::CFG_ETA:   eta_reg   <= cfg_data;
                br2_pkg::CFG_SCALE: scale_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    br2_front u_front (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
    );

    br2_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_job(fj),
        .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_job(bj)
    );

    br2_back #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
        .eta(eta_reg), .scale(scale_reg),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

typedef struct {
    logic signed [31:0] rhs_mean;
    logic signed [31:0] rhs_slope;
    logic signed [31:0] left_mean;
    logic signed [31:0] left_slope;
    logic signed [31:0] right_mean;
    logic signed [31:0] right_slope;
    logic               last;
} rhs_result_t;

class br2_scoreboard;
    longint signed eta, scale;
    longint signed prv_m, prv_s, cen_m, cen_s, cen_rm, cen_rs;
    longint unsigned cen_w;
    int fill;
    rhs_result_t pending[$];
    int errors;

    function new();
        eta = 131072;
        scale = 65536;
        prv_m = 0; prv_s = 0; cen_m = 0; cen_s = 0; cen_rm = 0; cen_rs = 0;
        cen_w = 0;
        fill = 0;
        errors = 0;
    endfunction

    function longint signed sat(longint signed v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // operands are already within 32 bits, so 64-bit math cannot wrap
    function longint signed qmul(longint signed a, longint signed b);
        logic [127:0] p;
        logic [127:0] r;
        longint unsigned ma, mb;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        p = ma * mb;
        r = p >> 16;
        if (r > 128'd2147483648) r = 128'd2147483648;
        if ((a < 0) != (b < 0)) return sat(-longint'(r));
        return sat(longint'(r));
    endfunction

    function longint signed qdiv(longint signed a, longint unsigned d);
        logic [127:0] n;
        logic [127:0] q;
        longint unsigned ma;
        ma = (a < 0) ? -a : a;
        n = ma;
        q = (n << 16) / d;
        if (q > 128'd2147483648) q = 128'd2147483648;
        if (a < 0) return sat(-longint'(q));
        return sat(longint'(q));
    endfunction

    function void note_cell(logic signed [31:0] m, logic signed [31:0] s, logic [30:0] w,
                            logic signed [31:0] rm, logic signed [31:0] rs,
                            bit start, bit fin);
        longint signed jl, jr, ql, qr, l0, l1, r0, r1, g, fl, fr, rmo, rso, t;
        longint unsigned h;
        rhs_result_t res;
        if (start) fill = 0;
        if (fill >= 2) begin
            h = (cen_w != 0) ? cen_w : 1;
            jl = sat(sat(prv_m + prv_s) - sat(cen_m - cen_s));
            jr = sat(sat(longint'(m) - longint'(s)) - sat(cen_m + cen_s));
            ql = qdiv(qmul(eta, jl), 2 * h);
            qr = qdiv(qmul(eta, jr), 2 * h);
            l0 = sat(-ql);
            l1 = sat(ql + sat(ql + ql));
            r0 = sat(-qr);
            r1 = sat(-sat(qr + sat(qr + qr)));
            g = qdiv(cen_s, h);
            fl = sat(g - sat(l0 - l1));
            fr = sat(g - sat(r0 + r1));
            rmo = sat(cen_rm + qmul(scale, sat(fr - fl)));
            rso = sat(cen_rs + qmul(scale, sat(fr + fl)));
            t = qmul(scale, sat(sat(g - l0) - r0));
            rso = sat(rso - sat(t + t));
            res.rhs_mean = rmo[31:0];
            res.rhs_slope = rso[31:0];
            res.left_mean = l0[31:0];
            res.left_slope = l1[31:0];
            res.right_mean = r0[31:0];
            res.right_slope = r1[31:0];
            res.last = fin;
            pending.push_back(res);
        end
        prv_m = cen_m;
        prv_s = cen_s;
        cen_m = m;
        cen_s = s;
        cen_w = w;
        cen_rm = rm;
        cen_rs = rs;
        if (fill < 2) fill++;
        if (fin) fill = 0;
    endfunction

    function void check_result(logic [br2_pkg::OUT_DATA_BITS-1:0] d, logic lst);
        rhs_result_t e;
        if (pending.size() == 0) begin
            $error("unexpected result transaction");
            errors++;
            return;
        end
        e = pending.pop_front();
        if (d[31:0] !== e.rhs_mean) begin
            $error("rhs_mean_out exp %h got %h", e.rhs_mean, d[31:0]); errors++;
        end
        if (d[63:32] !== e.rhs_slope) begin
            $error("rhs_slope_out exp %h got %h", e.rhs_slope, d[63:32]); errors++;
        end
        if (d[95:64] !== e.left_mean) begin
            $error("lift_left_mean exp %h got %h", e.left_mean, d[95:64]); errors++;
        end
        if (d[127:96] !== e.left_slope) begin
            $error("lift_left_slope exp %h got %h", e.left_slope, d[127:96]); errors++;
        end
        if (d[159:128] !== e.right_mean) begin
            $error("lift_right_mean exp %h got %h", e.right_mean, d[159:128]); errors++;
        end
        if (d[191:160] !== e.right_slope) begin
            $error("lift_right_slope exp %h got %h", e.right_slope, d[191:160]); errors++;
        end
        if (lst !== e.last) begin
            $error("last_result exp %0d got %0d", e.last, lst); errors++;
        end
    endfunction
endclass

module tb_top;
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [br2_pkg::IN_DATA_BITS-1:0] s_axis_tdata = '0;
    logic [1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [br2_pkg::OUT_DATA_BITS-1:0] m_axis_tdata;
    logic m_axis_tlast;
    logic cfg_we = 1'b0;
    logic cfg_index = 1'b0;
    logic [br2_pkg::IO_BITS-1:0] cfg_data = '0;

    br2_scoreboard sb = new();
    bit rand_stall = 1'b1;
    int out_wait = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    br2_diffusion_rhs_p1 dut (.*);

    task automatic write_reg(logic idx, logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == br2_pkg::CFG_ETA) sb.eta = longint'($signed(val));
        else sb.scale = longint'($signed(val));
    endtask

    // tvalid stays high into the next transaction when no gap is drawn
    task automatic send_cell(logic [31:0] m, logic [31:0] s, logic [30:0] w,
                             logic [31:0] rm, logic [31:0] rs, bit start, bit fin);
        int gap;
        gap = rand_stall ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, rs, rm, w, s, m};
        s_axis_tuser <= {fin, start};
        do @(posedge clk); while (!s_axis_tready);
        sb.note_cell(m, s, w, rm, rs, start, fin);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 32'h3_0000) - 32'h1_8000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] rand_width();
        case ($urandom_range(0, 5))
            0: return 31'd0;
            1: return 31'h7fff_ffff;
            2: return 31'($urandom_range(1, 32'h4_0000));
            default: return 31'($urandom);
        endcase
    endfunction

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic send_row(int cells);
        for (int i = 0; i < cells; i++)
            send_cell(rand_word(), rand_word(), rand_width(), rand_word(), rand_word(),
                      i == 0, i == cells - 1);
    endtask

    // result side: draw a wait after each transaction, check every transaction
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
        begin
            sb.check_result(m_axis_tdata, m_axis_tlast);
            out_wait = rand_stall ? int'($urandom_range(0, 5)) : 0;
            m_axis_tready <= (out_wait == 0);
        end
        else if (!m_axis_tready)
        begin
            if (out_wait > 0) out_wait--;
            m_axis_tready <= (out_wait == 0);
        end
    end

    initial
    begin
        int sent;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: extremes, zero width, rows without start, start mid window
        send_cell(32'h7fff_ffff, 32'h8000_0000, 31'd0, 32'h7fff_ffff, 32'h8000_0000, 1, 0);
        send_cell(32'h8000_0000, 32'h7fff_ffff, 31'd0, 32'h8000_0000, 32'h7fff_ffff, 0, 0);
        send_cell(32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0);
        send_cell(32'h0001_0000, 32'hffff_0000, 31'h0001_0000, 32'h0, 32'h0, 0, 0);
        send_cell(32'h0, 32'h0, 31'd1, 32'hffff_ffff, 32'hffff_ffff, 0, 1);
        send_cell(32'h0002_0000, 32'h0000_8000, 31'h0000_8000, 32'h1, 32'h2, 0, 0);
        send_cell(32'h0001_0000, 32'h0, 31'h0001_0000, 32'h3, 32'h4, 0, 0);
        send_cell(32'h0, 32'h0001_0000, 31'h0002_0000, 32'h5, 32'h6, 1, 0);
        send_cell(32'hffff_0000, 32'h0, 31'h0001_0000, 32'h7, 32'h8, 0, 0);
        send_cell(32'h0003_0000, 32'h0001_0000, 31'h0001_0000, 32'h9, 32'ha, 0, 0);
        send_cell(32'h8000_0000, 32'h8000_0000, 31'h0, 32'h8000_0000, 32'h8000_0000, 0, 1);
        wait_drain();
        write_reg(br2_pkg::CFG_ETA, 32'h7fff_ffff);
        write_reg(br2_pkg::CFG_SCALE, 32'h8000_0000);
        send_row(5);
        wait_drain();
        write_reg(br2_pkg::CFG_ETA, 32'h8000_0000);
        write_reg(br2_pkg::CFG_SCALE, 32'h7fff_ffff);
        send_row(4);
        wait_drain();
        sent = 20;
        for (int phase = 0; phase < 4; phase++)
        begin
            write_reg(br2_pkg::CFG_ETA, phase == 3 ? 32'h0 : rand_word());
            write_reg(br2_pkg::CFG_SCALE, phase == 2 ? 32'h0 : rand_word());
            rand_stall = (phase != 1);
            while (sent < 150 * (phase + 1))
            begin
                if ($urandom_range(0, 9) == 0) begin
                    send_cell(rand_word(), rand_word(), rand_width(), rand_word(), rand_word(),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    sent++;
                end else begin
                    int cells;
                    cells = $urandom_range(3, 12);
                    send_row(cells);
                    sent += cells;
                end
            end
            // hold input until the block has drained
            wait_drain();
        end
        rand_stall = 1'b1;
        if (sb.errors == 0)
            $display("[br2_diffusion_rhs_p1] OK");
        else
            $display("[br2_diffusion_rhs_p1] ERROR");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("[br2_diffusion_rhs_p1] ERROR");
        $finish;
    end
endmodule
